// ----- design/cpm_directory_scan_free_map_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the directory scan block
// Both modules clock their checks on clk and disable them during rst.
// ----------------------------------------------------------------------------
`ifndef CPM_DIRECTORY_SCAN_FREE_MAP_DEFINES_SVH
`define CPM_DIRECTORY_SCAN_FREE_MAP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check the consequent in the same cycle as the antecedent.
`define CPM_DSFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check the consequent in the cycle after the antecedent.
`define CPM_DSFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPM_DSFM_ASSERT_NOW(label, ante, cons, msg)
`define CPM_DSFM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- design/cpm_dsfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_dsfm_pkg
// Shared types and fixed constants of the directory scan and free map block.
// ----------------------------------------------------------------------------
package cpm_dsfm_pkg;

  // Request commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kinds
  typedef enum logic {
    KIND_EXTENT = 1'b0,
    KIND_MAP    = 1'b1
  } kind_t;

  // Directory entry layout
  localparam int          EXTENT_BYTES = 32;
  localparam int          POS_W        = 5;
  localparam logic [7:0]  UNUSED_MARK  = 8'hE5;
  localparam logic [4:0]  POS_STATUS   = 5'd0;
  localparam logic [4:0]  POS_BC       = 5'd13;
  localparam logic [4:0]  POS_RC       = 5'd15;
  localparam logic [4:0]  POS_BLOCKS   = 5'd16;
  localparam logic [4:0]  POS_LAST     = 5'(EXTENT_BYTES - 1);
  localparam int          RECORD_SHIFT = 7;   // 128-byte records

  // Free map organization: rows of 64 blocks
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int MAP_ROWS  = 4;
  localparam int ROW_W     = 2;
  localparam int MAP_BITS  = MAP_ROWS * WORD_BITS;

  localparam int LEN_W = 17;

  // Control from the scan logic to the free map store
  typedef struct packed {
    logic             rd;      // read a row for the request being accepted
    logic             clr;     // scan start: return the map to its reset contents
    logic [ROW_W-1:0] row;     // row to read
    logic             wr;      // mark the held block used and write the row back
    logic [BIT_W-1:0] wr_bit;  // block within the held row
  } map_ctl_t;

endpackage

// ----- design/cpm_dsfm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_dsfm_if
// Request and result channels of the directory scan block.
// ----------------------------------------------------------------------------
interface cpm_dsfm_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       scan_start;
  logic [1:0] word_index;

  modport source (output valid, cmd, data_byte, scan_start, word_index, input ready);
  modport sink   (input valid, cmd, data_byte, scan_start, word_index, output ready);
endinterface

interface cpm_dsfm_rsp_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [4:0]         extent_index;
  logic               extent_in_use;
  logic signed [16:0] ext_length;
  logic [63:0]        map_word;

  modport source (output valid, result_kind, extent_index, extent_in_use, ext_length,
                  map_word, input ready);
  modport sink   (input valid, result_kind, extent_index, extent_in_use, ext_length,
                  map_word, output ready);
endinterface

// ----- design/cpm_dsfm_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_dsfm_map
// Free map store: rows of 64 block bits in a synchronous memory,
// with per-row valid bits for the reset contents and write-back forwarding.
// ----------------------------------------------------------------------------
`include "cpm_directory_scan_free_map_defines.svh"

module cpm_dsfm_map #(
  parameter int MAP_BLOCKS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cpm_dsfm_pkg::map_ctl_t  ctl,
  output logic [63:0]             row_word
);

  localparam int MB = cpm_dsfm_pkg::MAP_BITS;
  localparam logic [MB-1:0] MAP_MASK  = (MB'(1) << MAP_BLOCKS) - MB'(1);
  localparam logic [MB-1:0] RESET_MAP = MAP_MASK & ~MB'(1);

  logic [63:0] mem [cpm_dsfm_pkg::MAP_ROWS];

  logic [cpm_dsfm_pkg::MAP_ROWS-1:0] row_ok;
  logic [cpm_dsfm_pkg::ROW_W-1:0]    rd_row;
  logic [63:0]                       rd_data;
  logic                              rd_ok;
  logic                              wb_valid;
  logic [cpm_dsfm_pkg::ROW_W-1:0]    wb_row;
  logic [63:0]                       wb_data;
  logic [63:0]                       wr_data;
  logic [63:0]                       base;
  logic [7:0]                        row_base;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data <= mem[ctl.row];
    end
    if (ctl.wr) begin
      mem[rd_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_row <= ctl.row;
      rd_ok  <= row_ok[ctl.row];
    end
    if (ctl.wr) begin
      wb_row  <= rd_row;
      wb_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok   <= '0;
      wb_valid <= 1'b0;
    end else begin
      if (ctl.wr) begin
        row_ok[rd_row] <= 1'b1;
        wb_valid       <= 1'b1;
      end
      // scan start wins over a write-back in the same cycle
      if (ctl.clr) begin
        row_ok   <= '0;
        wb_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    row_base = {rd_row, 6'd0};
    if (wb_valid && wb_row == rd_row) begin
      base = wb_data;
    end else if (rd_ok) begin
      base = rd_data;
    end else begin
      base = RESET_MAP[row_base +: 64];
    end
    row_word = base & MAP_MASK[row_base +: 64];
    wr_data  = row_word & ~(64'(1) << ctl.wr_bit);
  end

  `CPM_DSFM_ASSERT_NEXT(a_clr_empties_rows, ctl.clr, row_ok == '0, "map clear left a row valid")
  `CPM_DSFM_ASSERT_NOW(a_block0_never_written, ctl.wr, !(rd_row == '0 && ctl.wr_bit == '0),
    "write-back targets block 0")
  `CPM_DSFM_ASSERT_NOW(a_block0_reads_used, rd_row == '0, !row_word[0], "block 0 reads free")

endmodule

// ----- design/cpm_directory_scan_free_map.sv -----
`timescale 1ns / 1ps
// A request passes through stage 1 (map row read); a request that makes a
//   result then loads it into the output register. Throughput: one request
//   per cycle; the free map read-modify-write overlaps the next request
//   through write-back forwarding in the map store. A waiting result stalls
//   requests only once a second result-making request sits in the map stage.
// Reset (rst, synchronous): map reads as block 0 used, blocks 1 to
//   MAP_BLOCKS-1 free; scan position and counters go to zero.
// ----------------------------------------------------------------------------
// cpm_directory_scan_free_map
// Scans a streamed directory block extent by extent, keeps the block free
// map in a small memory and reports extent summaries and free-map words.
// ----------------------------------------------------------------------------
`include "cpm_directory_scan_free_map_defines.svh"

module cpm_directory_scan_free_map #(
  parameter int MAP_BLOCKS  = 256,
  parameter int EXTENTS     = 32,
  parameter int BLOCK_BYTES = 1024
) (
  input  logic           clk,
  input  logic           rst,
  cpm_dsfm_req_if.sink   req,
  cpm_dsfm_rsp_if.source rsp
);

  // --------------------------------------------------------------------------
  // Scan state, updated as each directory byte is accepted
  // --------------------------------------------------------------------------
  logic [4:0] pos;
  logic [4:0] ext_cnt;
  logic       ext_used;
  logic [4:0] nz;
  logic [7:0] rc;
  logic [7:0] bc;

  logic [4:0] pos_eff, pos_next;
  logic [4:0] ext_eff, ext_next;
  logic [5:0] ext_inc;
  logic       used_next;
  logic [4:0] nz_next;
  logic [7:0] rc_next, bc_next;
  logic       is_read, start, mark, last;
  logic       accept;

  // Stage 1: request waiting on its map row from memory
  logic                                 s1_valid;
  cpm_dsfm_pkg::kind_t                  s1_kind;
  logic                                 s1_emit;
  logic                                 s1_mark;
  logic [cpm_dsfm_pkg::BIT_W-1:0]       s1_bit;
  logic [4:0]                           s1_ext;
  logic                                 s1_used;
  logic [4:0]                           s1_nz;
  logic [7:0]                           s1_rc;
  logic [7:0]                           s1_bc;
  logic                                 s1_go;

  // Output register
  logic        out_valid;
  logic        out_free;
  logic        out_kind;
  logic [4:0]  out_ext;
  logic        out_used;
  logic signed [16:0] out_len;
  logic [63:0] out_word;

  cpm_dsfm_pkg::map_ctl_t map_ctl;
  logic [63:0]            row_word;
  logic [31:0]            len_full;
  logic signed [16:0]     len;

  assign out_free = !out_valid || rsp.ready;
  // Let stage 1 move on unless it carries a result that cannot leave yet
  assign s1_go    = !s1_valid || !s1_emit || out_free;
  assign req.ready = s1_go;
  assign accept   = req.valid && s1_go;

  always_comb begin
    is_read   = req.cmd == cpm_dsfm_pkg::CMD_READ;
    start     = !is_read && req.scan_start;
    pos_eff   = start ? '0 : pos;
    ext_eff   = start ? '0 : ext_cnt;
    used_next = ext_used;
    nz_next   = nz;
    rc_next   = rc;
    bc_next   = bc;
    mark      = 1'b0;
    if (pos_eff == cpm_dsfm_pkg::POS_STATUS) begin
      // status byte opens a new extent
      used_next = req.data_byte != cpm_dsfm_pkg::UNUSED_MARK;
      nz_next   = '0;
      rc_next   = '0;
      bc_next   = '0;
    end else if (pos_eff == cpm_dsfm_pkg::POS_BC) begin
      bc_next = req.data_byte;
    end else if (pos_eff == cpm_dsfm_pkg::POS_RC) begin
      rc_next = req.data_byte;
    end else if (pos_eff >= cpm_dsfm_pkg::POS_BLOCKS) begin
      if (ext_used && req.data_byte != 8'd0) begin
        nz_next = nz + 5'd1;
        // blocks beyond the map count in the length but mark nothing
        mark    = {1'b0, req.data_byte} < 9'(MAP_BLOCKS);
      end
    end
    last     = pos_eff == cpm_dsfm_pkg::POS_LAST;
    pos_next = last ? '0 : pos_eff + 5'd1;
    ext_inc  = {1'b0, ext_eff} + 6'd1;
    if (!last) begin
      ext_next = ext_eff;
    end else if (ext_inc >= 6'(EXTENTS)) begin
      ext_next = '0;
    end else begin
      ext_next = ext_inc[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      ext_cnt  <= '0;
      ext_used <= 1'b0;
      nz       <= '0;
      rc       <= '0;
      bc       <= '0;
    end else if (accept && !is_read) begin
      pos      <= pos_next;
      ext_cnt  <= ext_next;
      ext_used <= used_next;
      nz       <= nz_next;
      rc       <= rc_next;
      bc       <= bc_next;
    end
  end

  // --------------------------------------------------------------------------
  // Free map store: read the row at accept, modify and write back in stage 1
  // --------------------------------------------------------------------------
  always_comb begin
    map_ctl.rd     = accept;
    map_ctl.clr    = accept && start;
    map_ctl.row    = is_read ? req.word_index : req.data_byte[7:6];
    map_ctl.wr     = s1_valid && s1_go && s1_mark;
    map_ctl.wr_bit = s1_bit;
  end

  cpm_dsfm_map #(
    .MAP_BLOCKS(MAP_BLOCKS)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .ctl      (map_ctl),
    .row_word (row_word)
  );

  // --------------------------------------------------------------------------
  // Stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_go) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_kind <= is_read ? cpm_dsfm_pkg::KIND_MAP : cpm_dsfm_pkg::KIND_EXTENT;
      s1_emit <= is_read || last;
      s1_mark <= !is_read && mark;
      s1_bit  <= req.data_byte[5:0];
      s1_ext  <= ext_eff;
      s1_used <= used_next;
      s1_nz   <= nz_next;
      s1_rc   <= rc_next;
      s1_bc   <= bc_next;
    end
  end

  // Length = (blocks - 1) * block size + records * 128 + BC, wrapped to 17 bits; zero for an unused extent
  always_comb begin
    len_full = (32'(s1_nz) - 32'd1) * 32'(BLOCK_BYTES)
             + (32'(s1_rc) << cpm_dsfm_pkg::RECORD_SHIFT) + 32'(s1_bc);
    len      = s1_used ? signed'(len_full[cpm_dsfm_pkg::LEN_W-1:0]) : '0;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_emit && s1_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_emit && s1_go) begin
      out_kind <= s1_kind;
      if (s1_kind == cpm_dsfm_pkg::KIND_MAP) begin
        out_ext  <= '0;
        out_used <= 1'b0;
        out_len  <= '0;
        out_word <= row_word;
      end else begin
        out_ext  <= s1_ext;
        out_used <= s1_used;
        out_len  <= len;
        out_word <= '0;
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.result_kind   = out_kind;
  assign rsp.extent_index  = out_ext;
  assign rsp.extent_in_use = out_used;
  assign rsp.ext_length    = out_len;
  assign rsp.map_word      = out_word;

  `CPM_DSFM_ASSERT_NEXT(a_read_to_stage1, accept && is_read,
    s1_valid && s1_kind == cpm_dsfm_pkg::KIND_MAP, "map read did not enter stage 1")
  `CPM_DSFM_ASSERT_NEXT(a_start_restarts_scan, accept && start,
    pos == 5'd1 && ext_cnt == '0, "scan start did not restart the scan")
  `CPM_DSFM_ASSERT_NEXT(a_blocked_result_held, s1_valid && s1_emit && !out_free,
    s1_valid && s1_emit, "blocked result dropped from stage 1")
  `CPM_DSFM_ASSERT_NOW(a_summary_word_zero, out_valid,
    out_kind == cpm_dsfm_pkg::KIND_MAP || out_word == '0, "extent summary carries map bits")

endmodule
